>>> rtl/core/scd_pkg.sv
// package: scancode codes, modifier bits, key maps and shared types
package scd_pkg;

	localparam int unsigned ScWidth   = 8;
	localparam int unsigned IdxWidth  = 7;
	localparam int unsigned CharWidth = 8;

	localparam logic [ScWidth-1:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [ScWidth-1:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [ScWidth-1:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [ScWidth-1:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [ScWidth-1:0] SC_CTRL_MAKE    = 8'h1D;
	localparam logic [ScWidth-1:0] SC_CTRL_BREAK   = 8'h9D;
	localparam logic [ScWidth-1:0] SC_ALT_MAKE     = 8'h38;
	localparam logic [ScWidth-1:0] SC_ALT_BREAK    = 8'hB8;
	localparam logic [ScWidth-1:0] SC_CAPS_MAKE    = 8'h3A;
	localparam logic [ScWidth-1:0] SC_CONSOLE_BASE = 8'h3B;
	localparam int unsigned        SC_BREAK_BIT    = 7;

	localparam logic [CharWidth-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CharWidth-1:0] CH_LOWER_C = 8'h63;

	localparam int unsigned MOD_SHIFT = 0;
	localparam int unsigned MOD_CTRL  = 1;
	localparam int unsigned MOD_ALT   = 2;
	localparam int unsigned MOD_CAPS  = 3;
	localparam int unsigned ModWidth  = 4;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_CONSOLE = 1'b1;

	typedef struct packed {
		logic emit;
		logic ctrl;
		logic alt;
		logic upper;
	} mod_info_t;

	function automatic logic [CharWidth-1:0] plain_map(input logic [IdxWidth-1:0] idx);
		logic [CharWidth-1:0] ch;
		case (idx)
			7'd1:  ch = 8'h1B;  7'd2:  ch = 8'h31;  7'd3:  ch = 8'h32;  7'd4:  ch = 8'h33;
			7'd5:  ch = 8'h34;  7'd6:  ch = 8'h35;  7'd7:  ch = 8'h36;  7'd8:  ch = 8'h37;
			7'd9:  ch = 8'h38;  7'd10: ch = 8'h39;  7'd11: ch = 8'h30;  7'd12: ch = 8'h2D;
			7'd13: ch = 8'h3D;  7'd14: ch = 8'h08;  7'd15: ch = 8'h09;  7'd16: ch = 8'h71;
			7'd17: ch = 8'h77;  7'd18: ch = 8'h65;  7'd19: ch = 8'h72;  7'd20: ch = 8'h74;
			7'd21: ch = 8'h79;  7'd22: ch = 8'h75;  7'd23: ch = 8'h69;  7'd24: ch = 8'h6F;
			7'd25: ch = 8'h70;  7'd26: ch = 8'h5B;  7'd27: ch = 8'h5D;  7'd28: ch = 8'h0A;
			7'd30: ch = 8'h61;  7'd31: ch = 8'h73;  7'd32: ch = 8'h64;  7'd33: ch = 8'h66;
			7'd34: ch = 8'h67;  7'd35: ch = 8'h68;  7'd36: ch = 8'h6A;  7'd37: ch = 8'h6B;
			7'd38: ch = 8'h6C;  7'd39: ch = 8'h3B;  7'd40: ch = 8'h27;  7'd41: ch = 8'h60;
			7'd43: ch = 8'h5C;  7'd44: ch = 8'h7A;  7'd45: ch = 8'h78;  7'd46: ch = 8'h63;
			7'd47: ch = 8'h76;  7'd48: ch = 8'h62;  7'd49: ch = 8'h6E;  7'd50: ch = 8'h6D;
			7'd51: ch = 8'h2C;  7'd52: ch = 8'h2E;  7'd53: ch = 8'h2F;  7'd57: ch = 8'h20;
			7'd71: ch = 8'hE0;  7'd72: ch = 8'hE2;  7'd73: ch = 8'hE6;  7'd74: ch = 8'h2D;
			7'd75: ch = 8'hE4;  7'd76: ch = 8'h35;  7'd77: ch = 8'hE5;  7'd78: ch = 8'h2B;
			7'd79: ch = 8'hE1;  7'd80: ch = 8'hE3;  7'd81: ch = 8'hE7;  7'd82: ch = 8'hE8;
			7'd83: ch = 8'hE9;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [CharWidth-1:0] shift_map(input logic [IdxWidth-1:0] idx);
		logic [CharWidth-1:0] ch;
		case (idx)
			7'd1:  ch = 8'h1B;  7'd2:  ch = 8'h21;  7'd3:  ch = 8'h40;  7'd4:  ch = 8'h23;
			7'd5:  ch = 8'h24;  7'd6:  ch = 8'h25;  7'd7:  ch = 8'h5E;  7'd8:  ch = 8'h26;
			7'd9:  ch = 8'h2A;  7'd10: ch = 8'h28;  7'd11: ch = 8'h29;  7'd12: ch = 8'h5F;
			7'd13: ch = 8'h2B;  7'd14: ch = 8'h08;  7'd15: ch = 8'h09;  7'd16: ch = 8'h51;
			7'd17: ch = 8'h57;  7'd18: ch = 8'h45;  7'd19: ch = 8'h52;  7'd20: ch = 8'h54;
			7'd21: ch = 8'h59;  7'd22: ch = 8'h55;  7'd23: ch = 8'h49;  7'd24: ch = 8'h4F;
			7'd25: ch = 8'h50;  7'd26: ch = 8'h7B;  7'd27: ch = 8'h7D;  7'd28: ch = 8'h0A;
			7'd30: ch = 8'h41;  7'd31: ch = 8'h53;  7'd32: ch = 8'h44;  7'd33: ch = 8'h46;
			7'd34: ch = 8'h47;  7'd35: ch = 8'h48;  7'd36: ch = 8'h4A;  7'd37: ch = 8'h4B;
			7'd38: ch = 8'h4C;  7'd39: ch = 8'h3A;  7'd40: ch = 8'h22;  7'd41: ch = 8'h7E;
			7'd43: ch = 8'h7C;  7'd44: ch = 8'h5A;  7'd45: ch = 8'h58;  7'd46: ch = 8'h43;
			7'd47: ch = 8'h56;  7'd48: ch = 8'h42;  7'd49: ch = 8'h4E;  7'd50: ch = 8'h4D;
			7'd51: ch = 8'h3C;  7'd52: ch = 8'h3E;  7'd53: ch = 8'h3F;  7'd57: ch = 8'h20;
			7'd71: ch = 8'hE0;  7'd72: ch = 8'hE2;  7'd73: ch = 8'hE6;  7'd74: ch = 8'h2D;
			7'd75: ch = 8'hE4;  7'd76: ch = 8'h35;  7'd77: ch = 8'hE5;  7'd78: ch = 8'h2B;
			7'd79: ch = 8'hE1;  7'd80: ch = 8'hE3;  7'd81: ch = 8'hE7;  7'd82: ch = 8'hE8;
			7'd83: ch = 8'hE9;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

>>> rtl/core/scancode_to_char_decoder.sv
// top level: set-1 scancode to character decoder
//
//  channel    | handshake                    | payload
//  -----------+------------------------------+------------------------------------------
//  scancode   | scancode_valid/scancode_stall | scancode
//  result     | result_valid/result_stall     | kind, char_code, interrupt_group,
//             |                              | console_index
//
//  one item per cycle sustained while result_stall is low; a result passes the map stage, then the output register
//  the modifier register updates at acceptance, the map rom is read in the same cycle
//  modifier and break codes give no result and leave the pipeline at once
//  reset clears the modifiers and both stage valids
//  a held result stalls the map stage, which then stalls the input
module scancode_to_char_decoder import scd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        scancode_valid,
	output logic                        scancode_stall,
	input  logic [ScWidth-1:0]          scancode,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        kind,
	output logic [CharWidth-1:0]        char_code,
	output logic                        interrupt_group,
	output logic signed [ScWidth-1:0]   console_index
);

	logic               in_fire;
	logic               load_s1;
	logic               load_out;
	mod_info_t          info;
	mod_info_t          info_s1;
	logic               valid_s1;
	logic [ScWidth-1:0] scancode_s1;
	logic [CharWidth-1:0] plain_s1;
	logic [CharWidth-1:0] shift_s1;

	logic                 kind_d;
	logic [CharWidth-1:0] char_d;
	logic                 intr_d;
	logic [ScWidth-1:0]   cidx_d;

	logic                 out_valid_q;
	logic                 kind_q;
	logic [CharWidth-1:0] char_q;
	logic                 intr_q;
	logic [ScWidth-1:0]   cidx_q;

	assign load_out       = valid_s1 & (~out_valid_q | ~result_stall);
	assign scancode_stall = valid_s1 & ~load_out;
	assign in_fire        = scancode_valid & ~scancode_stall;
	assign load_s1        = in_fire & info.emit;

	scd_modifier u_modifier (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (in_fire),
		.scancode (scancode),
		.info     (info)
	);

	scd_keymap_rom u_rom (
		.clk     (clk),
		.rd_en   (load_s1),
		.rd_idx  (scancode[IdxWidth-1:0]),
		.plain_q (plain_s1),
		.shift_q (shift_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			info_s1     <= info;
			scancode_s1 <= scancode;
		end
	end

	always_comb begin
		kind_d = KIND_CHAR;
		char_d = '0;
		intr_d = 1'b0;
		cidx_d = '0;
		if (info_s1.ctrl) begin
			char_d = CH_NEWLINE;
			intr_d = (plain_s1 == CH_LOWER_C);
		end else if (info_s1.alt) begin
			kind_d = KIND_CONSOLE;
			cidx_d = scancode_s1 - SC_CONSOLE_BASE;
		end else begin
			char_d = info_s1.upper ? shift_s1 : plain_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q <= kind_d;
			char_q <= char_d;
			intr_q <= intr_d;
			cidx_q <= cidx_d;
		end
	end

	assign result_valid    = out_valid_q;
	assign kind            = kind_q;
	assign char_code       = char_q;
	assign interrupt_group = intr_q;
	assign console_index   = $signed(cidx_q);

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		scancode_stall |-> valid_s1 && out_valid_q && result_stall)
		else $error("input stalled without a held item");

	a_console_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_CONSOLE |-> char_code == '0 && !interrupt_group)
		else $error("console switch item carries character fields");

	a_interrupt_newline: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && interrupt_group |-> char_code == CH_NEWLINE && kind == KIND_CHAR)
		else $error("interrupt request without newline");

	a_char_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_CHAR |-> console_index == '0)
		else $error("character item carries a console index");

endmodule

>>> rtl/core/scd_keymap_rom.sv
// synchronous key map rom: primary and secondary map read together into registered outputs
module scd_keymap_rom import scd_pkg::*; (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [IdxWidth-1:0]  rd_idx,
	output logic [CharWidth-1:0] plain_q,
	output logic [CharWidth-1:0] shift_q
);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			plain_q <= plain_map(rd_idx);
			shift_q <= shift_map(rd_idx);
		end
	end

endmodule

>>> rtl/core/scd_modifier.sv
// modifier flag register and scancode classification
module scd_modifier import scd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [ScWidth-1:0] scancode,
	output mod_info_t          info
);

	logic [ModWidth-1:0] flags_q;
	logic [ModWidth-1:0] flags_d;
	logic                is_mod;

	always_comb begin
		flags_d = flags_q;
		is_mod  = 1'b1;
		case (scancode)
			SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   flags_d[MOD_SHIFT] = 1'b1;
			SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: flags_d[MOD_SHIFT] = 1'b0;
			SC_CTRL_MAKE:                     flags_d[MOD_CTRL]  = 1'b1;
			SC_CTRL_BREAK:                    flags_d[MOD_CTRL]  = 1'b0;
			SC_ALT_MAKE:                      flags_d[MOD_ALT]   = 1'b1;
			SC_ALT_BREAK:                     flags_d[MOD_ALT]   = 1'b0;
			SC_CAPS_MAKE:                     flags_d[MOD_CAPS]  = ~flags_q[MOD_CAPS];
			default:                          is_mod = 1'b0;
		endcase
	end

	always_comb begin
		info.emit  = ~is_mod & ~scancode[SC_BREAK_BIT];
		info.ctrl  = flags_q[MOD_CTRL];
		info.alt   = flags_q[MOD_ALT];
		info.upper = flags_q[MOD_SHIFT] ^ flags_q[MOD_CAPS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (fire) begin
			flags_q <= flags_d;
		end
	end

	// ordinary codes never touch the modifiers
	a_emit_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		fire && info.emit |=> $stable(flags_q))
		else $error("modifier flags changed on an ordinary key");

endmodule
